// File: rtl/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point projection splatter package
// Shared codes, register indexes and the types that pass between the parts.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam logic [1:0] OP_PROJECT = 2'd0;
  localparam logic [1:0] OP_FILL    = 2'd1;

  localparam logic [2:0] ST_DRAWN   = 3'd0;
  localparam logic [2:0] ST_BEHIND  = 3'd1;
  localparam logic [2:0] ST_OUTSIDE = 3'd2;
  localparam logic [2:0] ST_FILLED  = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_X     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Y     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Z     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_U   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_V   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL = 4'd7;

  localparam logic [31:0] RST_TRIG      = 32'd16384;
  localparam logic [23:0] RST_FOCAL     = 24'd524288;
  localparam logic [31:0] RST_PRINCIPAL = 32'd8388736;

  localparam int X_W   = 37;
  localparam int YZ_W  = 40;
  localparam int NUM_W = 63;
  localparam int DEN_W = 39;
  localparam int CNT_W = 6;

  typedef struct packed {
    logic [31:0]        roll_trig;
    logic [31:0]        pitch_trig;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic [23:0]        focal_u;
    logic [23:0]        focal_v;
    logic [31:0]        principal_point;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [31:0]             color;
    logic [15:0]             ridx;
    logic signed [X_W-1:0]   x;
    logic signed [YZ_W-1:0]  y;
    logic signed [YZ_W-1:0]  z;
  } cmd_t;

endpackage

// File: rtl/pps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point projection splatter front end
// Takes items, moves the point of a projection into camera space and queues a command.
// ----------------------------------------------------------------------------
module pps_front (
  input  logic               clk,
  input  logic               rst,
  input  pps_pkg::cfg_t      cfg,
  input  logic               clearing,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [31:0]        color,
  input  logic [15:0]        read_index,
  output pps_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  logic               cmd_ready
);
  import pps_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_ROT1, F_ROT2, F_ROT3, F_ROT4, F_PUSH} fstate_t;

  fstate_t state;
  logic [1:0]             op;
  logic [31:0]            color_r;
  logic [15:0]            ridx;
  logic signed [33:0]     dx, dy, dz;
  logic signed [49:0]     p0, p1, p2, p3;
  logic signed [X_W-1:0]  x, w;
  logic signed [52:0]     q0, q1, q2, q3;
  logic signed [YZ_W-1:0] y, z;
  logic signed [15:0]     ca, sa, cb, sb;
  logic signed [50:0]     sx, sw;
  logic signed [53:0]     sy, sz;

  always_comb begin
    ca = cfg.roll_trig[31:16];
    sa = cfg.roll_trig[15:0];
    cb = cfg.pitch_trig[31:16];
    sb = cfg.pitch_trig[15:0];
    sx = {p0[49], p0} - {p1[49], p1};
    sw = {p2[49], p2} + {p3[49], p3};
    sy = {q0[52], q0} - {q1[52], q1};
    sz = {q2[52], q2} + {q3[52], q3};
  end

  assign in_ready  = (state == F_IDLE) && !clearing;
  assign cmd_valid = (state == F_PUSH);
  assign cmd       = '{op: op, color: color_r, ridx: ridx, x: x, y: y, z: z};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            op      <= operation;
            color_r <= color;
            ridx    <= read_index;
            dx      <= 34'(point_x) - 34'(cfg.cam_x);
            dy      <= -34'(point_z) - 34'(cfg.cam_y);
            dz      <= 34'(point_y) - 34'(cfg.cam_z);
            state   <= (operation == OP_PROJECT) ? F_ROT1 : F_PUSH;
          end
        end
        F_ROT1: begin
          p0    <= cb * dx;
          p1    <= sb * dz;
          p2    <= sb * dx;
          p3    <= cb * dz;
          state <= F_ROT2;
        end
        F_ROT2: begin
          x     <= sx[50:14];
          w     <= sw[50:14];
          state <= F_ROT3;
        end
        F_ROT3: begin
          q0    <= ca * dy;
          q1    <= sa * w;
          q2    <= sa * dy;
          q3    <= ca * w;
          state <= F_ROT4;
        end
        F_ROT4: begin
          y     <= sy[53:14];
          z     <= sz[53:14];
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (cmd_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/pps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point projection splatter command queue
// Two-entry queue that lets the front and back ends stall independently.
// ----------------------------------------------------------------------------
module pps_queue (
  input  logic          clk,
  input  logic          rst,
  input  pps_pkg::cmd_t wr_data,
  input  logic          wr_valid,
  output logic          wr_ready,
  output pps_pkg::cmd_t rd_data,
  output logic          rd_valid,
  input  logic          rd_ready
);
  import pps_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/pps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point projection splatter back end
// Divides by depth, owns the frame store and registers each result.
// ----------------------------------------------------------------------------
module pps_back #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  pps_pkg::cfg_t cfg,
  output logic          clearing,
  input  pps_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    status,
  output logic [15:0]   pixel_index,
  output logic [31:0]   pixel_data
);
  import pps_pkg::*;

  localparam int STORE_SIZE = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

  typedef enum logic [3:0] {
    B_CLEAR, B_IDLE, B_MUL, B_PREP, B_DIV, B_FIX1, B_FIX2, B_WRITE,
    B_FILL, B_RWAIT, B_READ, B_OUT
  } bstate_t;

  bstate_t state;
  logic [31:0]            mem [STORE_SIZE];
  logic [31:0]            rdata;
  logic [ADDR_W-1:0]      sweep, rd_addr;
  logic                   rd_in_range;
  logic [31:0]            color_r;
  logic signed [X_W-1:0]  x;
  logic signed [YZ_W-1:0] y;
  logic [DEN_W-1:0]       den;
  logic signed [63:0]     mu, mv, qu, qv;
  logic                   neg_u, neg_v;
  logic [NUM_W-1:0]       qr_u, qr_v;
  logic [DEN_W-1:0]       rem_u, rem_v;
  logic [CNT_W-1:0]       cnt;
  logic                   outside;
  logic [31:0]            idx;
  logic [DEN_W:0]         tu, tv;
  logic                   geu, gev;
  logic [DEN_W-1:0]       rem_u_next, rem_v_next;
  logic [63:0]            qinc_u, qinc_v;
  logic signed [64:0]     u, v;
  logic [52:0]            col, row;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [31:0]            mem_wdata;

  always_comb begin
    tu         = {rem_u, qr_u[NUM_W-1]};
    tv         = {rem_v, qr_v[NUM_W-1]};
    geu        = tu >= {1'b0, den};
    gev        = tv >= {1'b0, den};
    rem_u_next = geu ? DEN_W'(tu - {1'b0, den}) : tu[DEN_W-1:0];
    rem_v_next = gev ? DEN_W'(tv - {1'b0, den}) : tv[DEN_W-1:0];
    qinc_u     = {1'b0, qr_u} + 64'(|rem_u);
    qinc_v     = {1'b0, qr_v} + 64'(|rem_v);
    u          = {qu[63], qu} + 65'({cfg.principal_point[15:0], 12'd0});
    v          = {qv[63], qv} + 65'({cfg.principal_point[31:16], 12'd0});
    col        = u[64:12];
    row        = v[64:12];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = color_r;
    priority case (state)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      B_FILL:  mem_we = 1'b1;
      B_WRITE: begin
        mem_we    = !outside;
        mem_waddr = idx[ADDR_W-1:0];
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[rd_addr];
  end

  assign clearing  = (state == B_CLEAR);
  assign cmd_ready = (state == B_IDLE);
  assign out_valid = (state == B_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      sweep <= '0;
    end else begin
      unique case (state)
        B_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == LAST_ADDR) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (cmd_valid) begin
            color_r     <= cmd.color;
            x           <= cmd.x;
            y           <= cmd.y;
            den         <= cmd.z[DEN_W-1:0];
            status      <= ST_READ;
            pixel_index <= '0;
            pixel_data  <= '0;
            if (cmd.op == OP_FILL) begin
              sweep <= '0;
              state <= B_FILL;
            end else if (cmd.op == OP_PROJECT) begin
              if (cmd.z[YZ_W-1] || cmd.z == '0) begin
                status <= ST_BEHIND;
                state  <= B_OUT;
              end else begin
                state <= B_MUL;
              end
            end else begin
              rd_addr     <= ADDR_W'(32'(cmd.ridx));
              rd_in_range <= 32'(cmd.ridx) < 32'(STORE_SIZE);
              pixel_index <= cmd.ridx;
              state       <= B_RWAIT;
            end
          end
        end
        B_MUL: begin
          mu    <= x * signed'({1'b0, cfg.focal_u});
          mv    <= y * signed'({1'b0, cfg.focal_v});
          state <= B_PREP;
        end
        B_PREP: begin
          neg_u <= mu[63];
          neg_v <= mv[63];
          qr_u  <= mu[63] ? (~mu[NUM_W-1:0] + 1'b1) : mu[NUM_W-1:0];
          qr_v  <= mv[63] ? (~mv[NUM_W-1:0] + 1'b1) : mv[NUM_W-1:0];
          rem_u <= '0;
          rem_v <= '0;
          cnt   <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          qr_u  <= {qr_u[NUM_W-2:0], geu};
          qr_v  <= {qr_v[NUM_W-2:0], gev};
          rem_u <= rem_u_next;
          rem_v <= rem_v_next;
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_W - 1)) begin
            state <= B_FIX1;
          end
        end
        B_FIX1: begin
          qu    <= neg_u ? (~qinc_u + 1'b1) : {1'b0, qr_u};
          qv    <= neg_v ? (~qinc_v + 1'b1) : {1'b0, qr_v};
          state <= B_FIX2;
        end
        B_FIX2: begin
          outside <= u[64] || v[64] || (col >= 53'(FRAME_WIDTH))
                     || (row >= 53'(FRAME_HEIGHT));
          idx     <= 32'(row[11:0]) * 32'(FRAME_WIDTH) + 32'(col[11:0]);
          state   <= B_WRITE;
        end
        B_WRITE: begin
          status      <= outside ? ST_OUTSIDE : ST_DRAWN;
          pixel_index <= outside ? 16'd0 : idx[15:0];
          state       <= B_OUT;
        end
        B_FILL: begin
          sweep <= sweep + 1'b1;
          if (sweep == LAST_ADDR) begin
            status <= ST_FILLED;
            state  <= B_OUT;
          end
        end
        B_RWAIT: state <= B_READ;
        B_READ: begin
          pixel_data <= rd_in_range ? rdata : 32'd0;
          state      <= B_OUT;
        end
        B_OUT: begin
          if (out_ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/point_projection_splatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point projection splatter
// Projects world points through a pinhole camera into a 32-bit frame store.
// ----------------------------------------------------------------------------
// Items enter on the in_valid/in_ready channel and each gives exactly one
// result beat on out_valid/out_ready, in order. Registers are written on the
// cfg channel, which is always ready, while the block is idle; the user must
// ensure this, since the block itself does not enforce it. A projection
// passes through the rotation states of the front end and then the back end,
// whose 63-step shared-rate divider runs the horizontal and vertical divides
// side by side. A fill walks the store at one pixel a cycle. A read passes
// through the registered store in the B_RWAIT and B_READ states.
// A two-entry command queue lets the front end take further items while the
// back end works or while a result waits for out_ready.
// After reset the store is cleared at one pixel a cycle; no item is taken
// meanwhile. A stalled receiver holds the result beat and, once the queue
// is full, in_ready.
// ----------------------------------------------------------------------------
module point_projection_splatter #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic signed [31:0]            point_x,
  input  logic signed [31:0]            point_y,
  input  logic signed [31:0]            point_z,
  input  logic [31:0]                   color,
  input  logic [15:0]                   read_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [15:0]                   pixel_index,
  output logic [31:0]                   pixel_data
);
  import pps_pkg::*;

  cfg_t cfg;
  cmd_t f_cmd, b_cmd;
  logic f_valid, f_ready, b_valid, b_ready, clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{roll_trig: RST_TRIG, pitch_trig: RST_TRIG, cam_x: '0, cam_y: '0,
               cam_z: '0, focal_u: RST_FOCAL, focal_v: RST_FOCAL,
               principal_point: RST_PRINCIPAL};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROLL:      cfg.roll_trig       <= cfg_data;
        REG_PITCH:     cfg.pitch_trig      <= cfg_data;
        REG_CAM_X:     cfg.cam_x           <= cfg_data;
        REG_CAM_Y:     cfg.cam_y           <= cfg_data;
        REG_CAM_Z:     cfg.cam_z           <= cfg_data;
        REG_FOCAL_U:   cfg.focal_u         <= cfg_data[23:0];
        REG_FOCAL_V:   cfg.focal_v         <= cfg_data[23:0];
        REG_PRINCIPAL: cfg.principal_point <= cfg_data;
        default: ;
      endcase
    end
  end

  pps_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .clearing(clearing),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .color(color), .read_index(read_index),
    .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
  );

  pps_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(b_cmd), .rd_valid(b_valid), .rd_ready(b_ready)
  );

  pps_back #(
    .FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .clearing(clearing),
    .cmd(b_cmd), .cmd_valid(b_valid), .cmd_ready(b_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .pixel_index(pixel_index), .pixel_data(pixel_data)
  );

endmodule

// File: dv/pps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point projection splatter checker
// Watches the register, item and result channels, keeps its own camera
// registers and frame store, predicts one result per accepted item and
// compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module pps_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic signed [31:0]            point_x,
  input  logic signed [31:0]            point_y,
  input  logic signed [31:0]            point_z,
  input  logic [31:0]                   color,
  input  logic [15:0]                   read_index,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [2:0]                    status,
  input  logic [15:0]                   pixel_index,
  input  logic [31:0]                   pixel_data,
  output int                            fail_count,
  output int                            pending
);
  import pps_pkg::*;

  localparam int FW = 256;
  localparam int FH = 256;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] index;
    logic [31:0] data;
  } pixel_result_t;

  logic [31:0]        roll_q, pitch_q, principal_q;
  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic [23:0]        focal_u_q, focal_v_q;
  logic [31:0]        pixels [0:FW*FH-1];
  pixel_result_t      awaited [$];

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic pixel_result_t splat(input logic [1:0] op, input logic signed [31:0] px,
                                          input logic signed [31:0] py,
                                          input logic signed [31:0] pz,
                                          input logic [31:0] col_val,
                                          input logic [15:0] ridx);
    pixel_result_t r;
    longint ca, sa, cb, sb, dx, dy, dz, x, w, y, z, u, v, col, row;
    r = '0;
    if (op == OP_FILL) begin
      for (int i = 0; i < FW*FH; i++) pixels[i] = col_val;
      r.status = ST_FILLED;
      return r;
    end
    if (op != OP_PROJECT) begin
      r.status = ST_READ;
      r.index = ridx;
      r.data = (int'(ridx) < FW*FH) ? pixels[ridx] : 32'd0;
      return r;
    end
    ca = longint'($signed(roll_q[31:16]));
    sa = longint'($signed(roll_q[15:0]));
    cb = longint'($signed(pitch_q[31:16]));
    sb = longint'($signed(pitch_q[15:0]));
    dx = longint'(px) - longint'(cam_x_q);
    dy = -longint'(pz) - longint'(cam_y_q);
    dz = longint'(py) - longint'(cam_z_q);
    x = (cb * dx - sb * dz) >>> 14;
    w = (sb * dx + cb * dz) >>> 14;
    y = (ca * dy - sa * w) >>> 14;
    z = (sa * dy + ca * w) >>> 14;
    if (z <= 0) begin
      r.status = ST_BEHIND;
      return r;
    end
    u = floor_quot(x * longint'(focal_u_q), z) + (longint'(principal_q[15:0]) << 12);
    v = floor_quot(y * longint'(focal_v_q), z) + (longint'(principal_q[31:16]) << 12);
    col = u >>> 12;
    row = v >>> 12;
    if (u < 0 || v < 0 || col >= FW || row >= FH) begin
      r.status = ST_OUTSIDE;
      return r;
    end
    pixels[row*FW + col] = col_val;
    r.status = ST_DRAWN;
    r.index = 16'(row*FW + col);
    return r;
  endfunction

  initial fail_count = 0;
  assign pending = awaited.size();

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst) begin
      for (int i = 0; i < FW*FH; i++) pixels[i] = '0;
      roll_q = RST_TRIG;
      pitch_q = RST_TRIG;
      cam_x_q = '0;
      cam_y_q = '0;
      cam_z_q = '0;
      focal_u_q = RST_FOCAL;
      focal_v_q = RST_FOCAL;
      principal_q = RST_PRINCIPAL;
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROLL:      roll_q = cfg_data;
          REG_PITCH:     pitch_q = cfg_data;
          REG_CAM_X:     cam_x_q = cfg_data;
          REG_CAM_Y:     cam_y_q = cfg_data;
          REG_CAM_Z:     cam_z_q = cfg_data;
          REG_FOCAL_U:   focal_u_q = cfg_data[23:0];
          REG_FOCAL_V:   focal_v_q = cfg_data[23:0];
          REG_PRINCIPAL: principal_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        awaited.push_back(splat(operation, point_x, point_y, point_z, color, read_index));
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          report("result beat with nothing awaited, status", status, 0);
        end else begin
          want = awaited.pop_front();
          if (status !== want.status) report("status", status, want.status);
          if (pixel_index !== want.index) report("pixel_index", pixel_index, want.index);
          if (pixel_data !== want.data) report("pixel_data", pixel_data, want.data);
        end
      end
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point projection splatter testbench
// Drives directed and random projections, fills and reads under five camera
// settings with bursty input, a stalling receiver and one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import pps_pkg::*;

  logic                 clk, rst;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid, in_ready;
  logic [1:0]           operation;
  logic signed [31:0]   point_x, point_y, point_z;
  logic [31:0]          color;
  logic [15:0]          read_index;
  logic                 out_valid, out_ready;
  logic [2:0]           status;
  logic [15:0]          pixel_index;
  logic [31:0]          pixel_data;
  int                   fail_count, pending;
  int                   ready_pct;
  bit                   long_hold;
  int                   burst_left;
  int                   n_proj, n_fill, n_read;

  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [31:0] TRIG_ZERO = 32'h4000_0000;

  point_projection_splatter dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .color(color), .read_index(read_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .pixel_index(pixel_index), .pixel_data(pixel_data)
  );

  pps_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .color(color), .read_index(read_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .pixel_index(pixel_index), .pixel_data(pixel_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** point_projection_splatter: FAILED **");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) < ready_pct);
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_camera(input logic [31:0] roll, input logic [31:0] pitch,
                            input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] cz, input logic [31:0] fu,
                            input logic [31:0] fv, input logic [31:0] pp);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    write_reg(REG_ROLL, roll);
    write_reg(REG_PITCH, pitch);
    write_reg(REG_CAM_X, cx);
    write_reg(REG_CAM_Y, cy);
    write_reg(REG_CAM_Z, cz);
    write_reg(REG_FOCAL_U, fu);
    write_reg(REG_FOCAL_V, fv);
    write_reg(REG_PRINCIPAL, pp);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [1:0] op, input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz, input logic [31:0] c,
                           input logic [15:0] ridx);
    int gap;
    in_valid <= 1'b1;
    operation <= op;
    point_x <= px;
    point_y <= py;
    point_z <= pz;
    color <= c;
    read_index <= ridx;
    do @(posedge clk); while (!in_ready);
    if (op == OP_FILL) n_fill++;
    else if (op == OP_PROJECT) n_proj++;
    else n_read++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic random_item(input int fill_odds);
    int pick;
    logic [31:0] depth;
    pick = $urandom_range(0, 999);
    if (pick < fill_odds) begin
      send_item(OP_FILL, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 300) begin
      send_item($urandom_range(0, 1) ? OP_READ : OP_SPARE, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    end else if (pick < 400) begin
      send_item(OP_PROJECT, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      depth = $urandom_range(32'h0000_8000, 32'h0008_0000);
      send_item(OP_PROJECT, $signed($urandom_range(0, 2 * depth)) - $signed(depth),
                depth + $urandom_range(0, 32'h0001_0000),
                $signed($urandom_range(0, 2 * depth)) - $signed(depth),
                $urandom, $urandom);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_PROJECT;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    color = '0;
    read_index = '0;
    ready_pct = 100;
    long_hold = 1'b0;
    burst_left = 0;
    n_proj = 0;
    n_fill = 0;
    n_read = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset camera first, then a level camera with a 256-pixel focal gain.
    send_item(OP_PROJECT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hA5A5_5A5A, '0);
    send_item(OP_READ, '0, '0, '0, '0, 16'hFFFF);
    set_camera(TRIG_ZERO, TRIG_ZERO, '0, '0, '0, 32'h0010_0000, 32'h0010_0000,
               32'h0080_0080);
    send_item(OP_PROJECT, '0, 32'h0001_0000, '0, 32'h1234_5678, '0);
    send_item(OP_READ, '0, '0, '0, '0, 16'h8080);
    send_item(OP_PROJECT, '0, '0, '0, 32'hFFFF_FFFF, '0);
    send_item(OP_PROJECT, '0, 32'h8000_0000, '0, 32'hFFFF_FFFF, '0);
    send_item(OP_PROJECT, 32'h7FFF_FFFF, 32'h0001_0000, '0, 32'h0000_0001, '0);
    send_item(OP_PROJECT, 32'h8000_0000, 32'h0001_0000, 32'h8000_0000, 32'h1, '0);
    send_item(OP_PROJECT, 32'hFF80_0000, 32'h0001_0000, 32'hFF80_0000, 32'h2, '0);
    send_item(OP_PROJECT, 32'h007F_FFFF, 32'h0001_0000, 32'h007F_FFFF, 32'h3, '0);
    send_item(OP_PROJECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h4, '0);
    send_item(OP_READ, '0, '0, '0, '0, 16'h0000);
    send_item(OP_SPARE, '0, '0, '0, '0, 16'hFFFF);
    send_item(OP_FILL, '0, '0, '0, 32'hDEAD_BEEF, '0);
    send_item(OP_READ, '0, '0, '0, '0, 16'h1357);
    send_item(OP_PROJECT, 32'h0000_4000, 32'h0002_0000, 32'hFFFF_C000, 32'h0BAD_F00D, '0);
    send_item(OP_SPARE, '0, '0, '0, '0, 16'h8000);

    ready_pct = 60;
    long_hold = 1'b1;
    for (int i = 0; i < 300; i++) random_item(3);

    set_camera({16'h3B21, 16'h187E}, {16'h3EC5, 16'hF384}, $urandom_range(0, 32'h0002_0000),
               $urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h0002_0000),
               $urandom_range(32'h0004_0000, 32'h0020_0000),
               $urandom_range(32'h0004_0000, 32'h0020_0000), $urandom);
    ready_pct = 100;
    for (int i = 0; i < 300; i++) random_item(3);

    set_camera(32'hFFFF_FFFF, 32'h8000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
               32'h00FF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    ready_pct = 30;
    for (int i = 0; i < 300; i++) random_item(3);

    set_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    ready_pct = 80;
    for (int i = 0; i < 300; i++) random_item(3);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Run covered %0d projections, %0d fills and %0d reads", n_proj, n_fill, n_read);
    $display("over five camera settings with bursty input and receiver stalls.");
    if (fail_count == 0)
      $display("** point_projection_splatter: PASSED **");
    else
      $display("** point_projection_splatter: FAILED **");
    $finish;
  end

endmodule

// File: files.f
rtl/pps_pkg.sv
rtl/pps_front.sv
rtl/pps_queue.sv
rtl/pps_back.sv
rtl/point_projection_splatter.sv
dv/pps_checker.sv
dv/testbench.sv
